/* rtl/core/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sorted list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned ECNT_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // broadcast from the top to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

  // compare results of one cell against the broadcast key
  typedef struct packed {
    logic after;  // empty, or holds a value above the key
    logic ge;     // occupied and holds a value at or above the key
    logic eq;     // occupied and holds the key
  } cell_flags_t;

endpackage

`default_nettype wire

/* rtl/core/sle_cell.sv */
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted chain: holds a value, compares it with the key and
// takes a value from a neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell (
  input  wire                                   clk_i,
  input  wire                                   occ_i,
  input  wire signed [sle_pkg::VAL_W-1:0]       key_i,
  input  wire sle_pkg::cell_ctrl_t              ctrl_i,
  input  wire                                   prev_after_i,
  input  wire signed [sle_pkg::VAL_W-1:0]       prev_val_i,
  input  wire signed [sle_pkg::VAL_W-1:0]       next_val_i,
  output logic signed [sle_pkg::VAL_W-1:0]      val_o,
  output sle_pkg::cell_flags_t                  flags_o
);

  logic signed [sle_pkg::VAL_W-1:0] val_q;
  logic signed [sle_pkg::VAL_W-1:0] val_d;

  always_comb begin
    flags_o.after = !occ_i || (val_q > key_i);
    flags_o.ge    = occ_i && (val_q >= key_i);
    flags_o.eq    = occ_i && (val_q == key_i);
  end

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      // everything above the key moves one slot up
      if (prev_after_i) begin
        val_d = prev_val_i;
      end else if (flags_o.after) begin
        val_d = key_i;
      end
    end else if (ctrl_i.del && flags_o.ge) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* rtl/core/sorted_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted store of signed values in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// the result strobes in the cycle after the item is accepted
// throughput: one item per cycle; every cell compares and shifts at once
// reset: asynchronous, clears the count so the store reads as empty
// the receiver cannot stall, so busy_o stays low
`default_nettype none

module sorted_list_engine (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire  [sle_pkg::KIND_W-1:0]         kind_i,
  input  wire  signed [sle_pkg::VAL_W-1:0]   value_i,
  output logic                               done_o,
  output logic [sle_pkg::STAT_W-1:0]         status_o,
  output logic [sle_pkg::ECNT_W-1:0]         entry_count_o
);

  localparam int unsigned N = sle_pkg::CAPACITY;

  logic signed [sle_pkg::VAL_W-1:0] cell_val [N];
  sle_pkg::cell_flags_t             cell_flags [N];
  logic [N-1:0]                     eq_vec;
  logic [N-1:0]                     occ_vec;

  logic [sle_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       done_q;
  sle_pkg::status_e           status_q, status_d;
  logic                       accept;
  logic                       full;
  logic                       found;
  sle_pkg::cell_ctrl_t        ctrl;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == sle_pkg::CNT_W'(N));
  assign found  = |eq_vec;

  always_comb begin
    ctrl.ins = accept && (sle_pkg::kind_e'(kind_i) == sle_pkg::KIND_INSERT) && !full;
    ctrl.del = accept && (sle_pkg::kind_e'(kind_i) == sle_pkg::KIND_DELETE) && found;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             prev_after;
    logic signed [sle_pkg::VAL_W-1:0] prev_val;
    logic signed [sle_pkg::VAL_W-1:0] next_val;

    assign occ_vec[i] = (sle_pkg::CNT_W'(i) < count_q);
    assign eq_vec[i]  = cell_flags[i].eq;

    if (i == 0) begin : g_first
      assign prev_after = 1'b0;
      assign prev_val   = value_i;
    end else begin : g_mid
      assign prev_after = cell_flags[i-1].after;
      assign prev_val   = cell_val[i-1];
    end

    if (i == N - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    sle_cell u_cell (
      .clk_i        (clk_i),
      .occ_i        (occ_vec[i]),
      .key_i        (value_i),
      .ctrl_i       (ctrl),
      .prev_after_i (prev_after),
      .prev_val_i   (prev_val),
      .next_val_i   (next_val),
      .val_o        (cell_val[i]),
      .flags_o      (cell_flags[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.del) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    case (sle_pkg::kind_e'(kind_i))
      sle_pkg::KIND_INSERT: begin
        status_d = full ? sle_pkg::ST_FULL : sle_pkg::ST_DONE;
      end
      sle_pkg::KIND_DELETE, sle_pkg::KIND_FIND: begin
        status_d = found ? sle_pkg::ST_DONE : sle_pkg::ST_MISSING;
      end
      default: begin
        status_d = sle_pkg::ST_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = sle_pkg::ECNT_W'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sle_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_done_follows_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (done_o == $past(accept)))
    else $error("result strobe does not follow an accepted item");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == sle_pkg::ST_FULL)) |-> (count_q == sle_pkg::CNT_W'(N)))
    else $error("full status with room left");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && !done_o |-> $stable(count_q))
    else $error("count changed without an item");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted list engine against a behavioral copy of its store.
// A table of directed requests covers the empty and full store, duplicates,
// the extreme values and the unused kind. Random phases that lean toward
// filling or draining the store, or mix the two, follow. Every result is
// compared in status and count with the copy or with a pinned row's outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [sle_pkg::KIND_W-1:0] KIND_UNUSED  = 2'd3;
  localparam int unsigned                RANDOM_ITEMS = 1150;
  localparam int unsigned                CYCLE_LIMIT  = 200000;
  localparam int unsigned                MAX_REPORTS  = 10;

  typedef struct packed {
    logic [sle_pkg::STAT_W-1:0] status;
    logic [sle_pkg::ECNT_W-1:0] count;
  } outcome_t;

  typedef struct {
    logic [sle_pkg::KIND_W-1:0]       kind;
    logic signed [sle_pkg::VAL_W-1:0] value;
    int unsigned                      reps;
    bit                               pinned;
    outcome_t                         outcome;
  } stim_row_t;

  typedef enum int { PHASE_FILL, PHASE_DRAIN, PHASE_MIX } phase_mode_e;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start_i = 1'b0;
  logic [sle_pkg::KIND_W-1:0]         kind_i = '0;
  logic signed [sle_pkg::VAL_W-1:0]   value_i = '0;
  logic                               busy_o;
  logic                               done_o;
  logic [sle_pkg::STAT_W-1:0]         status_o;
  logic [sle_pkg::ECNT_W-1:0]         entry_count_o;

  // copy of the store, ascending
  logic signed [sle_pkg::VAL_W-1:0]   held_values [sle_pkg::CAPACITY];
  int                                 held_count = 0;

  outcome_t                           pending_outcomes [$];
  stim_row_t                          plan [$];
  bit                                 row_pinned = 1'b0;
  outcome_t                           pinned_outcome = '0;
  bit                                 idle_on = 1'b1;
  int unsigned                        mismatches = 0;
  int unsigned                        cycle_count = 0;
  outcome_t                           want;
  outcome_t                           got;

  sorted_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // applies one request to the store copy and returns its result
  function automatic outcome_t apply_request(
    input logic [sle_pkg::KIND_W-1:0]       kind,
    input logic signed [sle_pkg::VAL_W-1:0] value);
    int       pos;
    int       hit;
    int       i;
    outcome_t res;
    res.status = sle_pkg::ST_MISSING;
    hit = -1;
    if (kind == sle_pkg::KIND_DELETE || kind == sle_pkg::KIND_FIND) begin
      for (i = 0; i < held_count; i++) begin
        if (hit < 0 && held_values[i] == value) hit = i;
      end
    end
    case (kind)
      sle_pkg::KIND_INSERT: begin
        if (held_count >= sle_pkg::CAPACITY) begin
          res.status = sle_pkg::ST_FULL;
        end else begin
          // lands after any equal entries
          pos = 0;
          while (pos < held_count && held_values[pos] <= value) pos++;
          for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
          held_values[pos] = value;
          held_count++;
          res.status = sle_pkg::ST_DONE;
        end
      end
      sle_pkg::KIND_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
          res.status = sle_pkg::ST_DONE;
        end
      end
      sle_pkg::KIND_FIND: begin
        if (hit >= 0) res.status = sle_pkg::ST_DONE;
      end
      default: res.status = sle_pkg::ST_MISSING;
    endcase
    res.count = sle_pkg::ECNT_W'(held_count);
    return res;
  endfunction

  function automatic logic signed [sle_pkg::VAL_W-1:0] pick_operand(input bit prefer_held);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_held && held_count != 0 && r < 60) begin
      return held_values[$urandom_range(0, held_count - 1)];
    end
    r = $urandom_range(0, 99);
    // narrow range so equal values pile up
    if (r < 30) return $urandom_range(0, 12) - 6;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0000_0000;
        default: return 32'shffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input outcome_t exp_o, input outcome_t act_o);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: expected status %0d count %0d, got status %0d count %0d",
               exp_o.status, exp_o.count, act_o.status, act_o.count);
    end
  endtask

  // accepted items are predicted here, and results checked in the same step
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        want = apply_request(kind_i, value_i);
        if (row_pinned) want = pinned_outcome;
        pending_outcomes.push_back(want);
      end
      if (done_o) begin
        got.status = status_o;
        got.count  = entry_count_o;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result: status %0d count %0d", got.status, got.count);
          end
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status || got.count !== want.count) begin
            report_mismatch(want, got);
          end
        end
      end
    end
  end

  task automatic issue_request(input logic [sle_pkg::KIND_W-1:0] kind,
                               input logic signed [sle_pkg::VAL_W-1:0] value,
                               input bit pin, input outcome_t pin_outcome);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    row_pinned     = pin;
    pinned_outcome = pin_outcome;
    start_i <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_until_settled();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [sle_pkg::KIND_W-1:0] kind,
                         input logic signed [sle_pkg::VAL_W-1:0] value,
                         input int unsigned reps, input bit pin,
                         input logic [sle_pkg::STAT_W-1:0] status, input int count);
    stim_row_t row;
    row.kind           = kind;
    row.value          = value;
    row.reps           = reps;
    row.pinned         = pin;
    row.outcome.status = status;
    row.outcome.count  = sle_pkg::ECNT_W'(count);
    plan.push_back(row);
  endtask

  initial begin
    phase_mode_e                      mode;
    int unsigned                      issued;
    int unsigned                      len;
    int unsigned                      r;
    int unsigned                      ins_pct;
    logic [sle_pkg::KIND_W-1:0]       kind;
    logic signed [sle_pkg::VAL_W-1:0] value;

    //      kind                  value       reps pin status               count
    add_row(sle_pkg::KIND_FIND,   32'sh0000_0000, 1, 1, sle_pkg::ST_MISSING, 0);
    add_row(sle_pkg::KIND_DELETE, 32'sh8000_0000, 1, 1, sle_pkg::ST_MISSING, 0);
    add_row(KIND_UNUSED,          32'shffff_ffff, 1, 1, sle_pkg::ST_MISSING, 0);
    add_row(sle_pkg::KIND_INSERT, 32'sh7fff_ffff, 1, 1, sle_pkg::ST_DONE,    1);
    add_row(sle_pkg::KIND_INSERT, 32'sh8000_0000, 1, 1, sle_pkg::ST_DONE,    2);
    add_row(sle_pkg::KIND_INSERT, 32'sh0000_0000, 1, 1, sle_pkg::ST_DONE,    3);
    add_row(sle_pkg::KIND_INSERT, 32'sh0000_0000, 1, 1, sle_pkg::ST_DONE,    4);
    add_row(sle_pkg::KIND_FIND,   32'sh8000_0000, 1, 1, sle_pkg::ST_DONE,    4);
    add_row(sle_pkg::KIND_FIND,   32'sh7fff_ffff, 1, 1, sle_pkg::ST_DONE,    4);
    add_row(sle_pkg::KIND_FIND,   32'shffff_ffff, 1, 1, sle_pkg::ST_MISSING, 4);
    add_row(sle_pkg::KIND_FIND,   32'sh0000_0001, 1, 1, sle_pkg::ST_MISSING, 4);
    add_row(sle_pkg::KIND_DELETE, 32'sh0000_0000, 1, 1, sle_pkg::ST_DONE,    3);
    add_row(sle_pkg::KIND_FIND,   32'sh0000_0000, 1, 1, sle_pkg::ST_DONE,    3);
    add_row(KIND_UNUSED,          32'sh7fff_ffff, 1, 1, sle_pkg::ST_MISSING, 3);
    add_row(sle_pkg::KIND_INSERT, 32'sh5555_5555, 61, 0, sle_pkg::ST_DONE,   0);
    add_row(sle_pkg::KIND_INSERT, 32'shaaaa_aaaa, 1, 1, sle_pkg::ST_FULL,    64);
    add_row(sle_pkg::KIND_INSERT, 32'sh7fff_ffff, 1, 1, sle_pkg::ST_FULL,    64);
    add_row(sle_pkg::KIND_FIND,   32'sh5555_5555, 1, 1, sle_pkg::ST_DONE,    64);
    add_row(sle_pkg::KIND_DELETE, 32'sh8000_0000, 1, 1, sle_pkg::ST_DONE,    63);
    add_row(sle_pkg::KIND_INSERT, 32'shaaaa_aaaa, 1, 0, sle_pkg::ST_DONE,    0);
    add_row(sle_pkg::KIND_DELETE, 32'sh5555_5555, 61, 0, sle_pkg::ST_DONE,   0);
    add_row(sle_pkg::KIND_DELETE, 32'sh7fff_ffff, 1, 0, sle_pkg::ST_DONE,    0);
    add_row(sle_pkg::KIND_DELETE, 32'shaaaa_aaaa, 1, 0, sle_pkg::ST_DONE,    0);
    add_row(sle_pkg::KIND_DELETE, 32'sh0000_0000, 1, 1, sle_pkg::ST_DONE,    0);
    add_row(sle_pkg::KIND_DELETE, 32'sh0000_0000, 1, 1, sle_pkg::ST_MISSING, 0);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        issue_request(plan[i].kind, plan[i].value, plan[i].pinned, plan[i].outcome);
      end
    end
    wait_until_settled();

    // random phases, picked at random, grow, shrink or mix the store
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mode    = phase_mode_e'($urandom_range(0, 2));
      len     = $urandom_range(16, 96);
      idle_on = ($urandom_range(0, 3) != 0);
      ins_pct = (mode == PHASE_FILL) ? 85 : (mode == PHASE_DRAIN) ? 15 : 50;
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          kind  = KIND_UNUSED;
          value = pick_operand(1'b1);
        end else if (r < 18) begin
          kind  = sle_pkg::KIND_FIND;
          value = pick_operand(1'b1);
        end else if ($urandom_range(0, 99) < ins_pct) begin
          kind  = sle_pkg::KIND_INSERT;
          value = pick_operand($urandom_range(0, 4) == 0);
        end else begin
          kind  = sle_pkg::KIND_DELETE;
          value = pick_operand(1'b1);
        end
        issue_request(kind, value, 1'b0, '0);
        issued++;
      end
      if ($urandom_range(0, 3) == 0) wait_until_settled();
    end

    wait_until_settled();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
